// File: rtl/hktt_pkg.sv
// Types and codes shared by the host key trust table modules.
package hktt_pkg;

  typedef enum logic [1:0] {
    CMD_CHECK  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_REVOKE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    V_UNKNOWN = 2'd0,
    V_TRUSTED = 2'd1,
    V_CHANGED = 2'd2,
    V_REVOKED = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_ACT   = 2'd2,
    ST_SHIFT = 2'd3
  } state_t;

  typedef logic [6:0] used_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [63:0] host_key;
    logic [15:0] port_number;
    logic [63:0] print_digest;
  } in_t;

  typedef struct packed {
    verdict_t verdict;
    logic     ok;
    used_t    entries_used;
  } out_t;

  typedef struct packed {
    logic [63:0] host;
    logic [15:0] port;
    logic [63:0] print;
    logic        revoked;
  } entry_t;

endpackage

// File: rtl/hktt_store.sv
// Entry memory of the host key trust table: one write port, one registered read port.
module hktt_store #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  logic                   clk,
  input  logic [IDX_W-1:0]       rd_addr,
  output hktt_pkg::entry_t       rd_data,
  input  logic                   wr_en,
  input  logic [IDX_W-1:0]       wr_addr,
  input  hktt_pkg::entry_t       wr_data
);

  hktt_pkg::entry_t mem [DEPTH];
  hktt_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/host_key_trust_table_core.sv
// Top level of the host key trust table: command sequencer around the entry memory.
//
// Usage: drive in_data and raise start while busy is low; the item is taken at that
// clock edge and busy rises in the next cycle. Each item gives exactly one result,
// shown on out_data for one cycle while out_valid is high; the receiver cannot stall.
// The table keeps its entries packed in insertion order in a single-port-read memory.
// A lookup reads one entry per cycle and stops at the key or at the last entry in use.
// A remove then moves every later entry down by one, one entry per cycle; the scan and
// the moves together pass over the table once. A new item may start in the cycle in
// which the result is shown.
// Reset empties the table at once; no clearing pass runs, since only entries below the
// fill count are ever used.
module host_key_trust_table_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  hktt_pkg::in_t    in_data,
  output logic             out_valid,
  output hktt_pkg::out_t   out_data
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  hktt_pkg::state_t   state_r, state_nxt;
  hktt_pkg::in_t      req_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               found_r, found_nxt;
  hktt_pkg::entry_t   hit_r, hit_nxt;
  logic               out_valid_r, out_valid_nxt;
  hktt_pkg::out_t     out_r, out_nxt;

  logic [IDX_W-1:0]   rd_addr;
  hktt_pkg::entry_t   rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  hktt_pkg::entry_t   wr_data;

  logic               accept;
  logic               match;
  logic [CNT_W:0]     idx_p1;
  logic [CNT_W:0]     idx_p2;

  hktt_store #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign accept = start && !busy;
  assign match  = (rd_data.host == req_r.host_key) && (rd_data.port == req_r.port_number);
  assign idx_p1 = (CNT_W+1)'(idx_r) + (CNT_W+1)'(1);
  assign idx_p2 = (CNT_W+1)'(idx_r) + (CNT_W+1)'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hktt_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    hit_r   <= hit_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    hit_nxt       = hit_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rd_addr       = idx_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = hit_r;

    unique case (state_r)
      hktt_pkg::ST_IDLE: begin
        rd_addr = '0;
        if (accept) begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = (cnt_r == '0) ? hktt_pkg::ST_ACT : hktt_pkg::ST_SCAN;
        end
      end

      hktt_pkg::ST_SCAN: begin
        if (match) begin
          found_nxt = 1'b1;
          hit_nxt   = rd_data;
          state_nxt = hktt_pkg::ST_ACT;
        end else if (idx_p1 == (CNT_W+1)'(cnt_r)) begin
          state_nxt = hktt_pkg::ST_ACT;
        end else begin
          idx_nxt = idx_p1[IDX_W-1:0];
          rd_addr = idx_p1[IDX_W-1:0];
        end
      end

      hktt_pkg::ST_ACT: begin
        out_nxt.verdict = hktt_pkg::V_UNKNOWN;
        out_nxt.ok      = 1'b0;
        state_nxt       = hktt_pkg::ST_IDLE;
        unique case (req_r.cmd)
          hktt_pkg::CMD_CHECK: begin
            out_nxt.ok = 1'b1;
            if (found_r) begin
              if (hit_r.revoked) begin
                out_nxt.verdict = hktt_pkg::V_REVOKED;
              end else if (hit_r.print == req_r.print_digest) begin
                out_nxt.verdict = hktt_pkg::V_TRUSTED;
              end else begin
                out_nxt.verdict = hktt_pkg::V_CHANGED;
              end
            end
          end
          hktt_pkg::CMD_ADD: begin
            wr_data.host    = req_r.host_key;
            wr_data.port    = req_r.port_number;
            wr_data.print   = req_r.print_digest;
            wr_data.revoked = 1'b0;
            if (found_r) begin
              wr_en      = 1'b1;
              out_nxt.ok = 1'b1;
            end else if ((CNT_W+1)'(cnt_r) < (CNT_W+1)'(TABLE_DEPTH)) begin
              wr_en      = 1'b1;
              wr_addr    = IDX_W'(cnt_r);
              cnt_nxt    = cnt_r + CNT_W'(1);
              out_nxt.ok = 1'b1;
            end
          end
          hktt_pkg::CMD_REVOKE: begin
            if (found_r) begin
              wr_en           = 1'b1;
              wr_data.revoked = 1'b1;
              out_nxt.ok      = 1'b1;
            end
          end
          hktt_pkg::CMD_REMOVE: begin
            if (found_r) begin
              if (idx_p1 < (CNT_W+1)'(cnt_r)) begin
                rd_addr   = idx_p1[IDX_W-1:0];
                state_nxt = hktt_pkg::ST_SHIFT;
              end else begin
                cnt_nxt    = cnt_r - CNT_W'(1);
                out_nxt.ok = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
        if (state_nxt == hktt_pkg::ST_IDLE) begin
          out_valid_nxt        = 1'b1;
          out_nxt.entries_used = hktt_pkg::used_t'(cnt_nxt);
        end
      end

      hktt_pkg::ST_SHIFT: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
        if (idx_p2 < (CNT_W+1)'(cnt_r)) begin
          rd_addr = idx_p2[IDX_W-1:0];
          idx_nxt = idx_p1[IDX_W-1:0];
        end else begin
          cnt_nxt              = cnt_r - CNT_W'(1);
          state_nxt            = hktt_pkg::ST_IDLE;
          out_valid_nxt        = 1'b1;
          out_nxt.verdict      = hktt_pkg::V_UNKNOWN;
          out_nxt.ok           = 1'b1;
          out_nxt.entries_used = hktt_pkg::used_t'(cnt_nxt);
        end
      end

      default: begin
        state_nxt = hktt_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != hktt_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W+1)'(cnt_r) <= (CNT_W+1)'(TABLE_DEPTH))
    else $error("Entry count exceeds the table depth.");

  a_cnt_moves_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(cnt_r) |-> out_valid_r)
    else $error("Entry count changed without a result.");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy && $past(busy))
    else $error("Result shown without an item in progress.");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy || out_valid_r)
    else $error("Accepted item did not start work.");

  a_verdict_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.verdict != hktt_pkg::V_UNKNOWN) |-> out_r.ok)
    else $error("Check verdict given without success.");
`endif

endmodule

// File: verif/host_key_trust_table_core_tb.sv
// Self-checking testbench for the host key trust table core: directed and random commands.
`timescale 1ns / 1ps

module host_key_trust_table_core_tb;
  import hktt_pkg::*;

  localparam int DEPTH = 64;
  localparam int KEY_POOL = 72;
  localparam int SEGMENTS = 13;
  localparam int SEG_ITEMS = 110;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_CYCLES = 200;
  localparam logic [63:0] ALL_ONES = '1;

  typedef struct packed {
    in_t item;
    logic settle;
  } queued_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_valid;
  out_t out_data;

  host_key_trust_table_core #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the trust table.
  logic [63:0] tbl_host[DEPTH];
  logic [15:0] tbl_port[DEPTH];
  logic [63:0] tbl_print[DEPTH];
  logic tbl_revoked[DEPTH];
  int tbl_count = 0;

  queued_cmd_t pending_cmds[$];
  out_t awaited_replies[$];

  int n_errors = 0;
  int n_replies = 0;
  int cmd_seen[4] = '{0, 0, 0, 0};
  int verdict_seen[4] = '{0, 0, 0, 0};
  int n_full_rejects = 0;
  int n_absent_fails = 0;
  int peak_count = 0;
  int burst_left = 0;
  int gap_left = 0;

  function automatic out_t apply_to_table(in_t c);
    out_t r;
    int hit;
    hit = -1;
    r.verdict = V_UNKNOWN;
    r.ok = 1'b0;
    for (int i = 0; i < tbl_count; i++) begin
      if (hit < 0 && tbl_host[i] == c.host_key && tbl_port[i] == c.port_number) begin
        hit = i;
      end
    end
    case (c.cmd)
      CMD_CHECK: begin
        r.ok = 1'b1;
        if (hit >= 0) begin
          if (tbl_revoked[hit]) begin
            r.verdict = V_REVOKED;
          end else if (tbl_print[hit] == c.print_digest) begin
            r.verdict = V_TRUSTED;
          end else begin
            r.verdict = V_CHANGED;
          end
        end
        verdict_seen[int'(r.verdict)]++;
      end
      CMD_ADD: begin
        if (hit < 0 && tbl_count < DEPTH) begin
          hit = tbl_count;
          tbl_host[hit] = c.host_key;
          tbl_port[hit] = c.port_number;
          tbl_count++;
        end
        if (hit >= 0) begin
          tbl_print[hit] = c.print_digest;
          tbl_revoked[hit] = 1'b0;
          r.ok = 1'b1;
        end else begin
          n_full_rejects++;
        end
      end
      CMD_REMOVE: begin
        if (hit >= 0) begin
          for (int i = hit; i + 1 < tbl_count; i++) begin
            tbl_host[i] = tbl_host[i + 1];
            tbl_port[i] = tbl_port[i + 1];
            tbl_print[i] = tbl_print[i + 1];
            tbl_revoked[i] = tbl_revoked[i + 1];
          end
          tbl_count--;
          r.ok = 1'b1;
        end else begin
          n_absent_fails++;
        end
      end
      default: begin
        if (hit >= 0) begin
          tbl_revoked[hit] = 1'b1;
          r.ok = 1'b1;
        end else begin
          n_absent_fails++;
        end
      end
    endcase
    cmd_seen[int'(c.cmd)]++;
    if (tbl_count > peak_count) begin
      peak_count = tbl_count;
    end
    r.entries_used = used_t'(tbl_count);
    return r;
  endfunction

  task automatic queue_cmd(cmd_t op, logic [63:0] host, logic [15:0] port,
                           logic [63:0] print, logic settle);
    queued_cmd_t q;
    q.item.cmd = op;
    q.item.host_key = host;
    q.item.port_number = port;
    q.item.print_digest = print;
    q.settle = settle;
    pending_cmds.push_back(q);
  endtask

  task automatic report_mismatch(string what);
    $display("tb: mismatch at reply %0d: %s", n_replies, what);
    n_errors++;
  endtask

  // Driver: bursts of items with random gaps; a settle mark holds the item back until
  // every earlier item has been answered.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        awaited_replies.push_back(apply_to_table(in_data));
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() == 0) begin
          start <= 1'b0;
        end else if (pending_cmds[0].settle && awaited_replies.size() != 0) begin
          start <= 1'b0;
        end else begin
          in_data <= pending_cmds[0].item;
          pending_cmds.pop_front();
          start <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Monitor: every reply is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch("reply with no item outstanding");
      end else begin
        if (out_data.verdict !== awaited_replies[0].verdict) begin
          report_mismatch($sformatf("verdict %0d, expected %0d", out_data.verdict,
                                    awaited_replies[0].verdict));
        end
        if (out_data.ok !== awaited_replies[0].ok) begin
          report_mismatch($sformatf("ok %b, expected %b", out_data.ok,
                                    awaited_replies[0].ok));
        end
        if (out_data.entries_used !== awaited_replies[0].entries_used) begin
          report_mismatch($sformatf("entries_used %0d, expected %0d",
                                    out_data.entries_used,
                                    awaited_replies[0].entries_used));
        end
        awaited_replies.pop_front();
      end
      n_replies++;
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_valid) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [63:0] pool_host[KEY_POOL];
    logic [15:0] pool_port[KEY_POOL];
    logic [63:0] pool_print[KEY_POOL][2];
    int add_weight[SEGMENTS];
    logic [63:0] h;
    logic [15:0] p;
    logic [63:0] f;
    cmd_t op;
    int k;
    int r;

    add_weight = '{80, 80, 60, 35, 20, 55, 85, 70, 30, 15, 60, 90, 45};

    // Some keys share a host or a port with their neighbor, so both halves of the key
    // have to match.
    for (int i = 0; i < KEY_POOL; i++) begin
      pool_host[i] = (i % 3 == 1) ? pool_host[i - 1] : {$urandom, $urandom};
      pool_port[i] = (i % 5 == 2) ? pool_port[i - 1] : 16'($urandom_range(0, 65535));
      pool_print[i][0] = {$urandom, $urandom};
      pool_print[i][1] = {$urandom, $urandom};
    end

    // Directed opening on the empty table, then field extremes and each corner case.
    queue_cmd(CMD_CHECK, '0, '0, '0, 1'b0);
    queue_cmd(CMD_REMOVE, '0, '0, '0, 1'b0);
    queue_cmd(CMD_REVOKE, ALL_ONES, 16'hffff, ALL_ONES, 1'b0);
    queue_cmd(CMD_ADD, '0, '0, '0, 1'b0);
    queue_cmd(CMD_ADD, ALL_ONES, 16'hffff, ALL_ONES, 1'b0);
    queue_cmd(CMD_ADD, '0, 16'hffff, 64'h5a5a_a5a5_0f0f_f0f0, 1'b0);
    queue_cmd(CMD_ADD, ALL_ONES, '0, 64'ha5a5_5a5a_f0f0_0f0f, 1'b0);
    queue_cmd(CMD_CHECK, '0, '0, '0, 1'b0);
    queue_cmd(CMD_CHECK, '0, '0, ALL_ONES, 1'b0);
    queue_cmd(CMD_REVOKE, ALL_ONES, 16'hffff, '0, 1'b0);
    queue_cmd(CMD_CHECK, ALL_ONES, 16'hffff, ALL_ONES, 1'b0);
    queue_cmd(CMD_REVOKE, ALL_ONES, 16'hffff, '0, 1'b0);
    queue_cmd(CMD_ADD, ALL_ONES, 16'hffff, 64'h0123_4567_89ab_cdef, 1'b0);
    queue_cmd(CMD_CHECK, ALL_ONES, 16'hffff, 64'h0123_4567_89ab_cdef, 1'b0);
    queue_cmd(CMD_CHECK, ALL_ONES, 16'hfffe, 64'h0123_4567_89ab_cdef, 1'b0);
    queue_cmd(CMD_REMOVE, '0, '0, ALL_ONES, 1'b0);
    queue_cmd(CMD_CHECK, '0, '0, '0, 1'b0);
    queue_cmd(CMD_CHECK, '0, 16'hffff, 64'h5a5a_a5a5_0f0f_f0f0, 1'b0);
    queue_cmd(CMD_REMOVE, ALL_ONES, '0, '0, 1'b0);
    queue_cmd(CMD_REMOVE, ALL_ONES, '0, '0, 1'b0);
    queue_cmd(CMD_CHECK, ALL_ONES, 16'hffff, 64'h0123_4567_89ab_cdef, 1'b0);

    // Random segments with a shifting share of adds, so the table fills up, overflows
    // and drains again. Each segment starts once all earlier items are answered.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      for (int n = 0; n < SEG_ITEMS; n++) begin
        k = $urandom_range(0, KEY_POOL - 1);
        h = pool_host[k];
        p = pool_port[k];
        f = pool_print[k][$urandom_range(0, 1)];
        if ($urandom_range(0, 19) == 0) begin
          h = {$urandom, $urandom};
          p = 16'($urandom_range(0, 65535));
          f = {$urandom, $urandom};
        end
        r = $urandom_range(0, 99);
        if (r < add_weight[seg]) begin
          op = CMD_ADD;
        end else begin
          r = $urandom_range(0, 19);
          op = (r < 9) ? CMD_CHECK : (r < 16) ? CMD_REMOVE : CMD_REVOKE;
        end
        queue_cmd(op, h, p, f, n == 0);
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || start || awaited_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d checks, %0d adds, %0d removes, %0d revokes; peak fill %0d of %0d.",
             cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], peak_count, DEPTH);
    $display("Verdicts %0d/%0d/%0d/%0d; %0d full refusals, %0d absent keys, %0d mismatches.",
             verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3],
             n_full_rejects, n_absent_fails, n_errors);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
